// ===== src/ssmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ssmc_pkg;
	localparam int TARGET_BITS = 26;
	localparam int TOTAL_BITS = 20;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	// per-cycle command broadcast along the cell chain
	typedef struct packed {
		logic update;
		logic clear;
	} cell_cmd_t;
endpackage
`default_nettype wire

// ===== src/ssmc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One table entry: a prefix sum and its occurrence count. Entries fill in
// order; the free-slot token passes from cell to cell.
module ssmc_cell #(
	parameter int SUM_BITS = 27,
	parameter int CNT_BITS = 11,
	parameter bit SEED = 1'b0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ssmc_pkg::cell_cmd_t  cmd,
	input  wire [SUM_BITS-1:0]   key,
	input  wire                  prev_used,
	output logic                 used,
	output logic                 hit,
	output logic [CNT_BITS-1:0]  hit_cnt,
	input  wire                  any_hit
);
	import ssmc_pkg::*;

	logic                used_q;
	logic [SUM_BITS-1:0] val_q;
	logic [CNT_BITS-1:0] cnt_q;

	assign used    = used_q;
	assign hit     = used_q && (val_q == key);
	assign hit_cnt = hit ? cnt_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= SEED;
			val_q  <= '0;
			cnt_q  <= CNT_BITS'(SEED);
		end else if (cmd.clear) begin
			used_q <= SEED;
			val_q  <= '0;
			cnt_q  <= CNT_BITS'(SEED);
		end else if (cmd.update) begin
			if (hit) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!any_hit && !used_q && prev_used) begin
				used_q <= 1'b1;
				val_q  <= key;
				cnt_q  <= CNT_BITS'(1);
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/subarray_sum_match_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Subarray sum match counter.
// s_axis: tdata = sample_value[15:0], tlast = last_item.
// m_axis: tdata = match_count[19:0] zero-padded to 24 bits, tlast =
//   final_result, tuser = capacity_overflow.
// target_sum_we/target_sum write the target; the user writes it only while
// the block is idle, which the block itself does not enforce. Each transfer
// runs a lookup of (sum - target) across the cell chain, then the insert or
// count update of the new sum, then the result register. The block takes
// one item at a time, taking the next once the result register is loaded.
// The table is a row of MAX_ITEMS+1 cells compared in parallel; the free
// slot is found by the token that passes from each used cell to the next.
// Reset clears the sum, total and table (entry zero holds sum zero, count
// one) and keeps nothing pending. A stalled receiver holds the result in the
// output register; the block takes one more transfer, runs it through and
// waits with it in the output stage, accepting nothing until the result is
// taken.
module subarray_sum_match_counter #(
	parameter int MAX_ITEMS = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        target_sum_we,
	input  wire [25:0] target_sum,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample_value
	input  wire        s_axis_tlast,   // last_item
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // match_count
	output logic       m_axis_tlast,   // final_result
	output logic       m_axis_tuser    // capacity_overflow
);
	import ssmc_pkg::*;

	localparam int DEPTH = MAX_ITEMS + 1;
	localparam int IBITS = $clog2(MAX_ITEMS + 1);
	localparam int CNT_BITS = $clog2(MAX_ITEMS + 2);
	localparam int SUM_BITS = SAMPLE_BITS + IBITS + 1 > TARGET_BITS + 1 ?
		SAMPLE_BITS + IBITS + 1 : TARGET_BITS + 1;

	state_t state_q;
	logic signed [TARGET_BITS-1:0] target_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [IBITS-1:0] items_q;
	logic last_q, over_q;
	logic [TOTAL_BITS-1:0] out_cnt_q;
	logic out_last_q, out_over_q, out_valid_q;

	cell_cmd_t cmd;
	logic [SUM_BITS-1:0] key;
	logic [DEPTH-1:0] used, hit;
	logic [CNT_BITS-1:0] cnts [DEPTH];
	logic [CNT_BITS-1:0] cnt_or;
	logic any_hit;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic accept;
	logic [TOTAL_BITS:0] tsum;
	logic look_q;

	assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
	assign s_axis_tready = state_q == ST_IDLE && !look_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign any_hit = |hit;

	always_comb begin
		cnt_or = '0;
		for (int i = 0; i < DEPTH; i++) cnt_or = cnt_or | cnts[i];
	end

	always_comb begin
		cmd = '0;
		cmd.update = state_q == ST_LOOK && !over_q;
		cmd.clear = state_q == ST_OUT && last_q && (!out_valid_q || m_axis_tready);
		if (state_q == ST_IDLE)
			key = sum_q - SUM_BITS'(target_q);
		else
			key = sum_q;
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			ssmc_cell #(
				.SUM_BITS(SUM_BITS), .CNT_BITS(CNT_BITS), .SEED(g == 0)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .key(key),
				.prev_used(g == 0 ? 1'b1 : used[(g == 0) ? 0 : g-1]),
				.used(used[g]), .hit(hit[g]), .hit_cnt(cnts[g]),
				.any_hit(any_hit)
			);
		end
	endgenerate

	// key during IDLE is computed from sum_q after the sample is added,
	// so the sum is advanced on accept and the lookup runs in ST_LOOK's
	// predecessor cycle below.
	assign tsum = {1'b0, total_q} + (TOTAL_BITS+1)'(cnt_or);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_sum_we) begin
			target_q <= target_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q <= '0;
			total_q <= '0;
			items_q <= '0;
			last_q <= 1'b0;
			over_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_cnt_q <= '0;
			out_last_q <= 1'b0;
			out_over_q <= 1'b0;
			look_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (look_q) begin
						look_q <= 1'b0;
						if (!over_q && tsum[TOTAL_BITS]) total_q <= TOTAL_MAX;
						else if (!over_q) total_q <= tsum[TOTAL_BITS-1:0];
						state_q <= ST_LOOK;
					end else if (accept) begin
						last_q <= s_axis_tlast;
						over_q <= items_q == IBITS'(MAX_ITEMS);
						if (items_q != IBITS'(MAX_ITEMS)) begin
							sum_q <= sum_q + SUM_BITS'(sample);
							items_q <= items_q + 1'b1;
						end
						look_q <= 1'b1;
					end
				end
				ST_LOOK: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_cnt_q <= total_q;
						out_last_q <= last_q;
						out_over_q <= over_q;
						if (last_q) begin
							sum_q <= '0;
							total_q <= '0;
							items_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'b0, out_cnt_q};
	assign m_axis_tlast = out_last_q;
	assign m_axis_tuser = out_over_q;
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	localparam int MAX_ITEMS = 1024;
	localparam int TABLE_DEPTH = MAX_ITEMS + 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [19:0] count;
		logic        closes;
		logic        overflow;
	} tally_t;

	typedef struct {
		logic signed [15:0] sample;
		logic               last;
		logic               check_count;
		logic [19:0]        count;
		logic               overflow;
	} vec_t;

	logic clk = 0;
	logic arst_n = 0;
	logic target_sum_we = 0;
	logic [25:0] target_sum = '0;
	logic s_axis_tvalid = 0;
	wire s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic s_axis_tlast = 0;
	wire m_axis_tvalid;
	logic m_axis_tready = 0;
	wire [23:0] m_axis_tdata;
	wire m_axis_tlast;
	wire m_axis_tuser;

	subarray_sum_match_counter DUT (
		.clk(clk), .arst_n(arst_n),
		.target_sum_we(target_sum_we), .target_sum(target_sum),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	// predictor state
	longint goal;
	longint prefix;
	int unsigned total;
	int unsigned taken;
	int unsigned used;
	longint sum_vals[TABLE_DEPTH];
	int unsigned sum_hits[TABLE_DEPTH];

	tally_t pending_tallies[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_off = 0;
	bit stream_done = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int find_sum(longint v);
		for (int i = 0; i < used; i++)
			if (sum_vals[i] == v)
				return i;
		return -1;
	endfunction

	function automatic void clear_table();
		prefix = 0;
		total = 0;
		taken = 0;
		used = 1;
		sum_vals[0] = 0;
		sum_hits[0] = 1;
	endfunction

	function automatic tally_t tally_sample(logic signed [15:0] s, logic last);
		tally_t t;
		int h;
		t.overflow = 0;
		if (taken >= MAX_ITEMS) begin
			t.overflow = 1;
		end else begin
			taken++;
			prefix += s;
			h = find_sum(prefix - goal);
			if (h >= 0)
				total = (total + sum_hits[h] > 20'hFFFFF) ? 20'hFFFFF : total + sum_hits[h];
			h = find_sum(prefix);
			if (h >= 0) begin
				sum_hits[h]++;
			end else if (used < TABLE_DEPTH) begin
				sum_vals[used] = prefix;
				sum_hits[used] = 1;
				used++;
			end
		end
		t.count = total[19:0];
		t.closes = last;
		if (last)
			clear_table();
		return t;
	endfunction

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		tally_t exp_t;
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_tallies.size() == 0) begin
					$error("unexpected transfer count=%0d", m_axis_tdata[19:0]);
					errors++;
				end else begin
					exp_t = pending_tallies.pop_front();
					if (m_axis_tdata[19:0] !== exp_t.count) begin
						$error("match_count exp %0d got %0d", exp_t.count, m_axis_tdata[19:0]);
						errors++;
					end
					if (m_axis_tlast !== exp_t.closes) begin
						$error("final_result exp %0b got %0b", exp_t.closes, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser !== exp_t.overflow) begin
						$error("capacity_overflow exp %0b got %0b", exp_t.overflow,
							m_axis_tuser);
						errors++;
					end
				end
			end
			m_axis_tready <= hold_off ? 1'b0 : (quiet || stream_done) ? 1'b1 :
				($urandom_range(99) >= 23);
		end
	end

	initial begin
		int hold_cycles;
		wait (arst_n);
		#20000;
		hold_off = 1;
		hold_cycles = 0;
		while (hold_cycles < 200) begin
			@(posedge clk);
			hold_cycles++;
		end
		hold_off = 0;
	end

	task automatic push_sample(logic signed [15:0] s, logic last, bit chk,
			logic [19:0] cnt, logic ovf);
		tally_t t;
		if (!quiet) begin
			while ($urandom_range(99) < 23) begin
				s_axis_tvalid <= 0;
				@(posedge clk);
			end
		end
		t = tally_sample(s, last);
		if (chk && t.count !== cnt) begin
			$error("match_count exp %0d got %0d", cnt, t.count);
			errors++;
		end
		if (chk && t.overflow !== ovf) begin
			$error("capacity_overflow exp %0b got %0b", ovf, t.overflow);
			errors++;
		end
		pending_tallies.push_back(t);
		s_axis_tvalid <= 1;
		s_axis_tdata <= s;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic wait_empty();
		s_axis_tvalid <= 0;
		while (pending_tallies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_goal(logic [25:0] v);
		target_sum_we <= 1;
		target_sum <= v;
		@(posedge clk);
		target_sum_we <= 0;
		goal = $signed(v);
	endtask

	task automatic send_array(int len, int span);
		logic signed [15:0] s;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(3))
				0: s = 16'($urandom);
				default: s = 16'($signed($urandom_range(2 * span)) - span);
			endcase
			push_sample(s, (i == len - 1), 0, '0, 0);
		end
	endtask

	vec_t directed[] = '{
		'{16'sd0,      1'b0, 1'b1, 20'd1, 1'b0},
		'{16'sd0,      1'b0, 1'b1, 20'd3, 1'b0},
		'{16'sd0,      1'b1, 1'b1, 20'd6, 1'b0},
		'{16'sd0,      1'b1, 1'b1, 20'd1, 1'b0},
		'{16'sh7FFF,   1'b0, 1'b1, 20'd0, 1'b0},
		'{-16'sh8000,  1'b0, 1'b0, 20'd0, 1'b0},
		'{16'sd1,      1'b0, 1'b0, 20'd0, 1'b0},
		'{-16'sd1,     1'b0, 1'b0, 20'd0, 1'b0},
		'{16'sh5555,   1'b0, 1'b0, 20'd0, 1'b0},
		'{-16'sh5556,  1'b1, 1'b0, 20'd0, 1'b0}
	};

	initial begin
		int items;
		logic [25:0] goals[$];
		goal = 0;
		clear_table();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i])
			push_sample(directed[i].sample, directed[i].last, directed[i].check_count,
				directed[i].count, directed[i].overflow);
		wait_empty();

		// capacity: one full array plus extra items, all zero with target 0
		quiet = 1;
		for (int i = 0; i < MAX_ITEMS + 3; i++)
			push_sample(16'sd0, (i == MAX_ITEMS + 2), 0, '0, 0);
		quiet = 0;
		wait_empty();

		goals = '{26'h1FFFFFF, 26'h2000000, 26'd5, -26'sd3, 26'd0};
		items = 0;
		foreach (goals[g]) begin
			write_goal(goals[g]);
			while (items < (g + 1) * 24) begin
				int len;
				len = $urandom_range(1, 24);
				send_array(len, (goals[g] == 26'd0 || goals[g] == 26'd5 ||
					goals[g] == -26'sd3) ? 4 : 32767);
				items += len;
			end
			if (g == 2)
				quiet = 1;
			wait_empty();
			quiet = 0;
		end
		// longer array with small values at a moderate target
		write_goal(26'd7);
		send_array(40, 6);
		stream_done = 1;
		wait_empty();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
